@@ sv/aes_pkg.sv @@
`timescale 1ns / 1ps
package aes_pkg;

	typedef struct packed {
		logic        cmd;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} out_beat_t;

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	localparam logic [63:0] REG_KEY_HIGH = 64'd0;
	localparam logic [63:0] REG_KEY_LOW  = 64'd1;

	localparam logic [7:0] FWD_SUB [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SUB [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

@@ sv/aes_ram.sv @@
`timescale 1ns / 1ps
module aes_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 44
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/aes_round.sv @@
`timescale 1ns / 1ps
module cipher_round (
	input  logic [127:0] state,
	input  logic [127:0] rkey,
	input  logic         inverse,
	input  logic         first,
	input  logic         last,
	output logic [127:0] next
);

	logic [7:0] s   [16];
	logic [7:0] a   [16];
	logic [7:0] b   [16];
	logic [7:0] m   [16];
	logic [7:0] k   [16];
	logic [7:0] x2  [16];
	logic [7:0] x4  [16];
	logic [7:0] x8  [16];
	logic [7:0] e   [16];

	function automatic logic [7:0] gmul(input logic [7:0] v, input logic [3:0] c,
		input logic [7:0] v2, input logic [7:0] v4, input logic [7:0] v8);
		return (c[0] ? v : 8'h00) ^ (c[1] ? v2 : 8'h00) ^ (c[2] ? v4 : 8'h00)
			^ (c[3] ? v8 : 8'h00);
	endfunction

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i] = state[127 - 8*i -: 8];
			k[i] = rkey[127 - 8*i -: 8];
		end
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (inverse) begin
					a[r + 4*((c + r) & 3)] = s[r + 4*c];
				end else begin
					a[r + 4*c] = s[r + 4*((c + r) & 3)];
				end
			end
		end
		for (int i = 0; i < 16; i++) begin
			b[i] = inverse ? aes_pkg::INV_SUB[a[i]] : aes_pkg::FWD_SUB[a[i]];
		end
		// Decryption adds the key before the inverse column mix.
		for (int i = 0; i < 16; i++) begin
			e[i] = inverse ? (b[i] ^ k[i]) : b[i];
			x2[i] = aes_pkg::xtime(e[i]);
			x4[i] = aes_pkg::xtime(x2[i]);
			x8[i] = aes_pkg::xtime(x4[i]);
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				m[4*c + r] = 8'h00;
				for (int j = 0; j < 4; j++) begin
					logic [3:0] cf;
					unique case ((j - r) & 3)
						0: cf = inverse ? 4'd14 : 4'd2;
						1: cf = inverse ? 4'd11 : 4'd3;
						2: cf = inverse ? 4'd13 : 4'd1;
						default: cf = inverse ? 4'd9 : 4'd1;
					endcase
					m[4*c + r] ^= gmul(e[4*c + j], cf, x2[4*c + j], x4[4*c + j],
						x8[4*c + j]);
				end
			end
		end
		for (int i = 0; i < 16; i++) begin
			if (first) begin
				next[127 - 8*i -: 8] = s[i] ^ k[i];
			end else if (last) begin
				next[127 - 8*i -: 8] = inverse ? e[i] : (b[i] ^ k[i]);
			end else begin
				next[127 - 8*i -: 8] = inverse ? m[i] : (m[i] ^ k[i]);
			end
		end
	end

endmodule

@@ sv/aes128_block_cipher.sv @@
`timescale 1ns / 1ps
// AES-128 block cipher; all rounds run on a single shared round unit.
// Configuration: cfg_we, cfg_index, cfg_data write key_high (0) or key_low (1).
// Each key write starts a key expansion that writes 44 round-key words into a
// small RAM, one word per cycle; in_stall stays high meanwhile.
// Input channel: in_valid, in_stall, in_data (cmd, block_high, block_low).
// Output channel: out_valid, out_stall, out_data (result_high, result_low).
// A beat is accepted when valid is high, stall is low and no key write is taken.
// Each of the 11 rounds fetches its four round-key words through the registered
// RAM read port in ST_FETCH and then passes through the round unit in ST_ROUND;
// out_valid rises once the last round has been registered.
// The next input beat can be accepted in the cycle after the result beat.
// The result waits in the output register while out_stall is high; the next
// input beat is taken only after the result beat has gone.
// Reset clears the key to zero and expands the all-zero key before the
// first input beat is accepted.
module aes128_block_cipher (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [63:0]             cfg_index,
	input  logic [63:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  aes_pkg::in_beat_t       in_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output aes_pkg::out_beat_t      out_data
);

	typedef enum logic [2:0] {ST_EXPAND, ST_IDLE, ST_FETCH, ST_ROUND, ST_OUT} state_t;

	state_t       state_q;
	logic [63:0]  key_high_q;
	logic [63:0]  key_low_q;
	logic [5:0]   widx_q;
	logic [31:0]  w_q [4];
	logic [7:0]   rc_q;
	logic [127:0] blk_q;
	logic [127:0] rk_q;
	logic         inv_q;
	logic [3:0]   round_q;
	logic [2:0]   fetch_q;
	logic         ram_we;
	logic [5:0]   ram_raddr;
	logic [31:0]  ram_wdata;
	logic [31:0]  ram_rdata;
	logic [31:0]  t_word;
	logic [31:0]  rot;
	logic [127:0] round_next;
	logic [3:0]   key_round;

	always_comb begin
		rot = {w_q[3][23:0], w_q[3][31:24]};
		t_word = w_q[3];
		if (widx_q[1:0] == 2'd0) begin
			t_word = {aes_pkg::FWD_SUB[rot[31:24]] ^ rc_q, aes_pkg::FWD_SUB[rot[23:16]],
				aes_pkg::FWD_SUB[rot[15:8]], aes_pkg::FWD_SUB[rot[7:0]]};
		end
		if (widx_q < 6'd4) begin
			unique case (widx_q[1:0])
				2'd0: ram_wdata = key_high_q[63:32];
				2'd1: ram_wdata = key_high_q[31:0];
				2'd2: ram_wdata = key_low_q[63:32];
				default: ram_wdata = key_low_q[31:0];
			endcase
		end else begin
			ram_wdata = w_q[0] ^ t_word;
		end
		ram_we = (state_q == ST_EXPAND);
		key_round = inv_q ? (4'd10 - round_q) : round_q;
		ram_raddr = {key_round, fetch_q[1:0]};
	end

	aes_ram #(.WIDTH(32), .DEPTH(44)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (widx_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cipher_round u_round (
		.state   (blk_q),
		.rkey    (rk_q),
		.inverse (inv_q),
		.first   (round_q == 4'd0),
		.last    (round_q == 4'd10),
		.next    (round_next)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = {blk_q[127:64], blk_q[63:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_EXPAND;
			key_high_q <= '0;
			key_low_q  <= '0;
			widx_q     <= '0;
			w_q        <= '{default: '0};
			rc_q       <= 8'h01;
			blk_q      <= '0;
			rk_q       <= '0;
			round_q    <= '0;
			fetch_q    <= '0;
			inv_q      <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == aes_pkg::REG_KEY_HIGH ||
				cfg_index == aes_pkg::REG_KEY_LOW)) begin
				if (cfg_index == aes_pkg::REG_KEY_HIGH) begin
					key_high_q <= cfg_data;
				end else begin
					key_low_q <= cfg_data;
				end
				state_q <= ST_EXPAND;
				widx_q  <= '0;
				rc_q    <= 8'h01;
			end else begin
				unique case (state_q)
					ST_EXPAND: begin
						w_q[0] <= w_q[1];
						w_q[1] <= w_q[2];
						w_q[2] <= w_q[3];
						w_q[3] <= ram_wdata;
						if (widx_q >= 6'd4 && widx_q[1:0] == 2'd0) begin
							rc_q <= aes_pkg::xtime(rc_q);
						end
						if (widx_q == 6'd43) begin
							state_q <= ST_IDLE;
						end
						widx_q <= widx_q + 6'd1;
					end
					ST_IDLE: begin
						if (in_valid) begin
							blk_q   <= {in_data.block_high, in_data.block_low};
							inv_q   <= (in_data.cmd == aes_pkg::CMD_DECRYPT);
							round_q <= '0;
							fetch_q <= '0;
							state_q <= ST_FETCH;
						end
					end
					ST_FETCH: begin
						// The RAM read is registered, so read data lags the address.
						if (fetch_q != 3'd0) begin
							rk_q <= {rk_q[95:0], ram_rdata};
						end
						if (fetch_q == 3'd4) begin
							state_q <= ST_ROUND;
						end
						fetch_q <= fetch_q + 3'd1;
					end
					ST_ROUND: begin
						blk_q   <= round_next;
						fetch_q <= '0;
						if (round_q == 4'd10) begin
							state_q <= ST_OUT;
						end else begin
							round_q <= round_q + 4'd1;
							state_q <= ST_FETCH;
						end
					end
					default: begin
						if (!out_stall) begin
							state_q <= ST_IDLE;
						end
					end
				endcase
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_stall) |=> (state_q == ST_OUT && $stable(blk_q)))
		else $error("result changed under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXPAND && !cfg_we) |-> (widx_q <= 6'd43))
		else $error("expansion index overran the store");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (round_q <= 4'd10))
		else $error("round count overran");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> (fetch_q <= 3'd4))
		else $error("key fetch overran");

endmodule
